FILE: hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

`define ASSERT_CLK_NORST(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: hdl/m2m_pkg.sv
`timescale 1ns / 1ps
package m2m_pkg;

  localparam int AddrBitsDefault = 16;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_ADD      = 5'd1,
    OP_ADD_W    = 5'd2,
    OP_SUB      = 5'd3,
    OP_SUB_W    = 5'd4,
    OP_MUL      = 5'd5,
    OP_MUL_W    = 5'd6,
    OP_DIV      = 5'd7,
    OP_DIV_W    = 5'd8,
    OP_JUMP     = 5'd9,
    OP_JUMP_I   = 5'd10,
    OP_CMP      = 5'd11,
    OP_CMP_W    = 5'd12,
    OP_SET      = 5'd13,
    OP_SET_W    = 5'd14,
    OP_SET_I    = 5'd15,
    OP_SET_I_W  = 5'd16,
    OP_COPY     = 5'd17,
    OP_COPY_W   = 5'd18,
    OP_COPY_I   = 5'd19,
    OP_COPY_I_W = 5'd20
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_PA,
    ST_RD_PD,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_DIV,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] src_a;
    logic [15:0] src_b;
    logic [15:0] dst;
    logic [15:0] target;
    logic [15:0] imm;
    logic [15:0] fallthrough_ip;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_ip;
    logic        div_zero;
  } result_t;

endpackage

FILE: hdl/m2m_stream_if.sv
`timescale 1ns / 1ps
interface m2m_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mem_to_mem_instruction_executor_top.sv
`timescale 1ns / 1ps
// channel  direction  payload
// instr    in         action, src_a, src_b, dst, target, imm, fallthrough_ip
// result   out        next_ip, div_zero
// A byte read issues the address, then captures the data; a byte write issues both at once.
// An item runs its reads, execute and any writes between one accepted word and
// the next; a divide with a nonzero divisor also runs the divider per quotient bit.
// After reset the memory is cleared, one byte a cycle, all 2^ADDR_BITS bytes,
// before the first word is taken. The result waits in a register until taken;
// the next word is taken only after that.
module mem_to_mem_instruction_executor_top #(
  parameter int ADDR_BITS = m2m_pkg::AddrBitsDefault
) (
  input logic clk,
  input logic rst,
  m2m_stream_if.sink   instr,
  m2m_stream_if.source result
);
  import m2m_pkg::*;
  `include "assert_macros.svh"

  localparam int Depth = 1 << ADDR_BITS;

  logic [7:0] mem [Depth];

  state_t state, state_next;
  instr_t ins;
  logic [ADDR_BITS:0] clr_cnt;
  logic [15:0] pa, pd, va, vb, res;
  logic       wide, hi;
  logic [4:0] div_cnt;
  logic [15:0] rem;
  logic       dz;
  logic       dz_now;
  logic [15:0] nip;
  logic [7:0] rd_data;
  logic       mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0] mem_wdata;

  // reads return data in the next cycle; hi selects byte, sequencing via 'phase'
  logic phase;

  action_t act;
  assign act = action_t'(ins.action);

  logic uses_pa, uses_pd, uses_a, uses_b, writes, is_div;
  always_comb begin
    uses_pa = (act == OP_JUMP_I) || (act == OP_COPY_I) || (act == OP_COPY_I_W);
    uses_pd = (act == OP_SET_I) || (act == OP_SET_I_W) || (act == OP_COPY_I) ||
              (act == OP_COPY_I_W);
    uses_a  = (act inside {[OP_ADD:OP_DIV_W], OP_CMP, OP_CMP_W, OP_SET_I, OP_SET_I_W,
                           [OP_COPY:OP_COPY_I_W]});
    uses_b  = (act inside {[OP_ADD:OP_DIV_W], OP_CMP, OP_CMP_W});
    writes  = (act inside {[OP_ADD:OP_DIV_W], [OP_SET:OP_COPY_I_W]});
    is_div  = (act == OP_DIV) || (act == OP_DIV_W);
    wide    = (act inside {OP_ADD_W, OP_SUB_W, OP_MUL_W, OP_DIV_W, OP_CMP_W, OP_SET_W,
                           OP_SET_I_W, OP_COPY_W, OP_COPY_I_W});
  end

  // base address of the bytes accessed in the current state
  logic [15:0] base;
  always_comb begin
    case (state)
      ST_RD_PA: base = ins.src_a;
      ST_RD_PD: base = ins.dst;
      ST_RD_A:  base = uses_pa ? pa : ins.src_a;
      ST_RD_B:  base = ins.src_b;
      ST_WR:    base = uses_pd ? pd : ins.dst;
      default:  base = 16'd0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 8'd0;
    mem_addr  = ADDR_BITS'(base) + ADDR_BITS'(hi);
    if (state == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt[ADDR_BITS-1:0];
    end else if (state == ST_WR && !phase) begin
      mem_we    = 1'b1;
      mem_wdata = hi ? res[15:8] : res[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // a read state spends phase 0 issuing, phase 1 capturing, per byte
  logic byte_done, last_byte;
  logic wide_acc;
  assign byte_done = phase;
  assign last_byte = !wide_acc || hi;
  always_comb begin
    case (state)
      ST_RD_PA, ST_RD_PD: wide_acc = 1'b1;
      default:            wide_acc = wide;
    endcase
  end

  function automatic state_t after_pa(logic upd, logic ua);
    state_t s;
    s = upd ? ST_RD_PD : (ua ? ST_RD_A : ST_EXEC);
    return s;
  endfunction

  assign dz_now = wide ? (vb == 16'd0) : (vb[7:0] == 8'd0);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == (ADDR_BITS+1)'(Depth - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (instr.valid) begin
        state_next = ST_EXEC;
        if (action_t'(instr.data.action) inside {OP_JUMP_I, OP_COPY_I, OP_COPY_I_W})
          state_next = ST_RD_PA;
        else if (action_t'(instr.data.action) inside {OP_SET_I, OP_SET_I_W})
          state_next = ST_RD_PD;
        else if (action_t'(instr.data.action) inside {[OP_ADD:OP_DIV_W], OP_CMP,
                 OP_CMP_W, [OP_COPY:OP_COPY_W]})
          state_next = ST_RD_A;
      end
      ST_RD_PA: if (byte_done && last_byte)
        state_next = (act == OP_JUMP_I) ? ST_EXEC : after_pa(uses_pd, uses_a);
      ST_RD_PD: if (byte_done && last_byte) state_next = uses_a ? ST_RD_A : ST_EXEC;
      ST_RD_A:  if (byte_done && last_byte) state_next = uses_b ? ST_RD_B : ST_EXEC;
      ST_RD_B:  if (byte_done && last_byte) state_next = ST_EXEC;
      ST_EXEC:  state_next = (is_div && !dz_now) ? ST_DIV : (writes ? ST_WR : ST_DONE);
      ST_DIV:   if (div_cnt == 5'd1) state_next = ST_WR;
      ST_WR:    if (!phase && (!wide || hi)) state_next = ST_DONE;
      ST_DONE:  if (result.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    instr.ready         = (state == ST_IDLE);
    result.valid        = (state == ST_DONE);
    result.data.next_ip = nip;
    result.data.div_zero = dz;
  end

  // shared restoring divider step
  logic [16:0] trial;
  assign trial = {rem, res[15]} - {1'b0, vb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      phase   <= 1'b0;
      hi      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state != state_next) begin
        phase <= 1'b0;
        hi    <= 1'b0;
      end else if (state inside {ST_RD_PA, ST_RD_PD, ST_RD_A, ST_RD_B}) begin
        phase <= !phase;
        if (phase) hi <= 1'b1;
      end else if (state == ST_WR) begin
        hi <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (instr.valid) begin
        ins <= instr.data;
        dz  <= 1'b0;
        va  <= '0;
        vb  <= '0;
        nip <= instr.data.fallthrough_ip;
      end
      ST_RD_PA: if (phase) begin
        if (hi) pa[15:8] <= rd_data; else pa[7:0] <= rd_data;
      end
      ST_RD_PD: if (phase) begin
        if (hi) pd[15:8] <= rd_data; else pd[7:0] <= rd_data;
      end
      ST_RD_A: if (phase) begin
        if (hi) va[15:8] <= rd_data; else va[7:0] <= rd_data;
      end
      ST_RD_B: if (phase) begin
        if (hi) vb[15:8] <= rd_data; else vb[7:0] <= rd_data;
      end
      ST_EXEC: begin
        rem <= '0;
        case (act)
          OP_ADD, OP_ADD_W: res <= va + vb;
          OP_SUB, OP_SUB_W: res <= va - vb;
          OP_MUL, OP_MUL_W: res <= va * vb;
          OP_DIV, OP_DIV_W: begin
            if (dz_now) begin
              res <= 16'hFFFF;
              dz  <= 1'b1;
            end else begin
              res <= wide ? va : {va[7:0], 8'd0};
            end
            div_cnt <= wide ? 5'd16 : 5'd8;
          end
          OP_JUMP:   nip <= ins.target;
          OP_JUMP_I: nip <= pa;
          OP_CMP:    if (va[7:0] > vb[7:0]) nip <= ins.target;
          OP_CMP_W:  if (va > vb) nip <= ins.target;
          OP_SET, OP_SET_W: res <= ins.imm;
          default:   res <= va;
        endcase
      end
      ST_DIV: begin
        div_cnt <= div_cnt - 5'd1;
        if (!trial[16]) begin
          rem <= trial[15:0];
          res <= {res[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], res[15]};
          res <= {res[14:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_excl_hs, clk, rst, !(instr.ready && result.valid), "ready while result held")
  `ASSERT_CLK(a_res_hold, clk, rst,
    (result.valid && !result.ready) |=> (result.valid && $stable(result.data)),
    "result dropped")
  `ASSERT_CLK(a_div_len, clk, rst, (state == ST_DIV) |-> (div_cnt != 5'd0),
    "divider overrun")
endmodule
